@@ rtl/assert_macros.svh @@
// Assertion macros shared by the mailbox RTL.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define MPCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MPCM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mpcm_pkg.sv @@
// Types and constants for the multi-port character mailbox.
// No dependencies; used by the top level.
package mpcm_pkg;

    localparam int BYTE_W   = 8;
    localparam int MODE_W   = 3;
    localparam int PORT_IW  = 2;
    localparam int MASK_W   = 3;
    localparam int IN_USER_W  = MODE_W + PORT_IW;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_BUS_READ  = 3'd0,
        MODE_BUS_WRITE = 3'd1,
        MODE_TX_PUSH   = 3'd2,
        MODE_RX_POP    = 3'd3,
        MODE_TX_FLUSH  = 3'd4,
        MODE_RX_FLUSH  = 3'd5,
        MODE_START_OUT = 3'd6,
        MODE_INIT      = 3'd7
    } mode_t;

    // One result item, with the selects that pick the ring read data.
    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              data_valid;
        logic              tx_empty;
        logic              tx_full;
        logic              tx_half_full;
        logic              rx_empty;
        logic [MASK_W-1:0] avail_mask;
        logic              io_avail;
        logic              status_update;
        logic              push_dropped;
        logic              tx_sel;
        logic              rx_sel;
    } result_t;

endpackage

@@ rtl/multi_port_char_mailbox_rings.sv @@
// Multi-port character mailbox: per-port transmit and receive byte rings.
// Depends on mpcm_pkg and assert_macros.svh.
//
// Usage:
//   s_axis carries one command per transfer: tuser holds mode and port,
//   tdata holds the byte for a bus write or a transmit push.
//   m_axis returns exactly one result per command: tdata holds the byte
//   read plus ring and avail status, tuser is the data valid flag.
//   cfg_we / cfg_wdata load the terminator byte returned by a bus read of
//   an empty transmit ring; write it only while no command is in flight.
// The command register takes each input transfer, then the result register
//   captures the result with the ring read data.
// Throughput: one command per cycle while m_axis_tready is high, set by the
//   single write and single read port of each ring memory, which all ports share.
// Reset clears all ring indices, stop marks, avail bits and the io-avail
//   flag; ring contents are not cleared and no clearing pass is run.
// When m_axis_tready is low the result holds, the command register holds,
//   and s_axis_tready drops once the command register is occupied.
`include "assert_macros.svh"

module multi_port_char_mailbox_rings #(
    parameter int RING_DEPTH = 256,
    parameter int PORT_COUNT = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // config
    input  logic                               cfg_we,
    input  logic [mpcm_pkg::BYTE_W-1:0]        cfg_wdata,
    // command stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mpcm_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] data_in
    input  logic [mpcm_pkg::IN_USER_W-1:0]     s_axis_tuser,  // [2:0] mode, [4:3] port
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] data_out, [8] tx_empty, [9] tx_full, [10] tx_half_full, [11] rx_empty,
    // [14:12] avail_mask, [15] io_avail, [16] status_update, [17] push_dropped
    output logic [mpcm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser   // data_valid
);

    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W     = PTR_W + 1;
    localparam int PORT_W    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int MEM_DEPTH = PORT_COUNT * RING_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [PTR_W-1:0]  PTR_LAST    = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0]  HALF_CNT    = CNT_W'(RING_DEPTH / 2);
    localparam logic [ADDR_W-1:0] RING_STRIDE = ADDR_W'(RING_DEPTH);

    function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // ---------------- state ----------------
    logic [PTR_W-1:0]      tx_head_reg [PORT_COUNT];
    logic [PTR_W-1:0]      tx_tail_reg [PORT_COUNT];
    logic [PTR_W-1:0]      rx_head_reg [PORT_COUNT];
    logic [PTR_W-1:0]      rx_tail_reg [PORT_COUNT];
    logic [PORT_COUNT-1:0] stop_reg;
    logic [PORT_COUNT-1:0] avail_reg;
    logic                  io_avail_reg;
    logic [mpcm_pkg::BYTE_W-1:0] term_reg;

    logic [mpcm_pkg::BYTE_W-1:0] tx_mem [MEM_DEPTH];
    logic [mpcm_pkg::BYTE_W-1:0] rx_mem [MEM_DEPTH];
    logic [mpcm_pkg::BYTE_W-1:0] tx_rd_reg;
    logic [mpcm_pkg::BYTE_W-1:0] rx_rd_reg;

    // command register
    logic                          in_valid_reg;
    mpcm_pkg::mode_t               in_mode_reg;
    logic [mpcm_pkg::PORT_IW-1:0]  in_port_reg;
    logic [mpcm_pkg::BYTE_W-1:0]   in_data_reg;

    // result register
    logic              out_valid_reg;
    mpcm_pkg::result_t out_reg;

    // ---------------- handshake ----------------
    logic advance;
    logic step;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= '0;
        end
        else if (cfg_we)
        begin
            term_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg <= mpcm_pkg::mode_t'(s_axis_tuser[mpcm_pkg::MODE_W-1:0]);
            in_port_reg <= s_axis_tuser[mpcm_pkg::IN_USER_W-1:mpcm_pkg::MODE_W];
            in_data_reg <= s_axis_tdata;
        end
    end

    // ---------------- step logic ----------------
    logic                  present;
    logic [PORT_W-1:0]     port_idx;
    logic [PORT_COUNT-1:0] port_bit;
    logic [PTR_W-1:0]      th, tt, rh, rt;
    logic [PTR_W-1:0]      th_next, tt_next, rh_next, rt_next;
    logic                  stop_next;
    logic [PORT_COUNT-1:0] avail_next;
    logic                  io_avail_next;
    logic                  tx_we, rx_we;
    logic [CNT_W-1:0]      tx_fill;
    logic [ADDR_W-1:0]     base_addr;
    mpcm_pkg::result_t     res;

    assign present   = (4'(in_port_reg) < 4'(PORT_COUNT));
    assign port_idx  = PORT_W'(in_port_reg);
    assign port_bit  = PORT_COUNT'(1) << port_idx;
    assign th        = tx_head_reg[port_idx];
    assign tt        = tx_tail_reg[port_idx];
    assign rh        = rx_head_reg[port_idx];
    assign rt        = rx_tail_reg[port_idx];
    assign base_addr = ADDR_W'(port_idx) * RING_STRIDE;

    always_comb
    begin
        th_next       = th;
        tt_next       = tt;
        rh_next       = rh;
        rt_next       = rt;
        stop_next     = stop_reg[port_idx];
        avail_next    = avail_reg;
        io_avail_next = io_avail_reg;
        tx_we         = 1'b0;
        rx_we         = 1'b0;
        res           = '0;
        if (in_mode_reg == mpcm_pkg::MODE_INIT)
        begin
            th_next           = '0;
            tt_next           = '0;
            rh_next           = '0;
            rt_next           = '0;
            avail_next        = '0;
            io_avail_next     = 1'b0;
            res.status_update = 1'b1;
        end
        else if (present)
        begin
            unique case (in_mode_reg)
                mpcm_pkg::MODE_BUS_READ:
                begin
                    res.data_valid = 1'b1;
                    if (th == tt)
                    begin
                        res.data_out = term_reg;
                        if (stop_reg[port_idx])
                        begin
                            avail_next        = avail_reg & ~port_bit;
                            io_avail_next     = 1'b0;
                            res.status_update = 1'b1;
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        res.tx_sel = 1'b1;
                        tt_next    = nxt(tt);
                        stop_next  = 1'b0;
                    end
                end
                mpcm_pkg::MODE_BUS_WRITE:
                begin
                    // overwrite the oldest byte when full
                    rx_we   = 1'b1;
                    rh_next = nxt(rh);
                    if (nxt(rh) == rt)
                    begin
                        rt_next = nxt(rt);
                    end
                end
                mpcm_pkg::MODE_TX_PUSH:
                begin
                    if (nxt(th) == tt)
                    begin
                        res.push_dropped = 1'b1;
                    end
                    else
                    begin
                        tx_we   = 1'b1;
                        th_next = nxt(th);
                    end
                end
                mpcm_pkg::MODE_RX_POP:
                begin
                    if (rh != rt)
                    begin
                        res.rx_sel     = 1'b1;
                        res.data_valid = 1'b1;
                        rt_next        = nxt(rt);
                    end
                end
                mpcm_pkg::MODE_TX_FLUSH:
                begin
                    th_next = '0;
                    tt_next = '0;
                end
                mpcm_pkg::MODE_RX_FLUSH:
                begin
                    rh_next = '0;
                    rt_next = '0;
                end
                mpcm_pkg::MODE_START_OUT:
                begin
                    if (th != tt)
                    begin
                        avail_next        = avail_reg | port_bit;
                        io_avail_next     = 1'b1;
                        res.status_update = 1'b1;
                    end
                end
                mpcm_pkg::MODE_INIT:
                begin
                    // handled above
                end
            endcase
        end

        tx_fill = (th_next >= tt_next) ? (CNT_W'(th_next) - CNT_W'(tt_next))
                                       : (DEPTH_CNT - CNT_W'(tt_next) + CNT_W'(th_next));
        if (present)
        begin
            res.tx_empty     = (th_next == tt_next);
            res.tx_full      = (nxt(th_next) == tt_next);
            res.tx_half_full = (tx_fill > HALF_CNT);
            res.rx_empty     = (rh_next == rt_next);
        end
        else
        begin
            res.tx_empty = 1'b1;
            res.rx_empty = 1'b1;
        end
        res.avail_mask = mpcm_pkg::MASK_W'(avail_next);
        res.io_avail   = io_avail_next;
    end

    // ---------------- pointer and flag registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                tx_head_reg[p] <= '0;
                tx_tail_reg[p] <= '0;
                rx_head_reg[p] <= '0;
                rx_tail_reg[p] <= '0;
            end
            stop_reg     <= '0;
            avail_reg    <= '0;
            io_avail_reg <= 1'b0;
        end
        else if (step)
        begin
            if (in_mode_reg == mpcm_pkg::MODE_INIT)
            begin
                for (int p = 0; p < PORT_COUNT; p++)
                begin
                    tx_head_reg[p] <= '0;
                    tx_tail_reg[p] <= '0;
                    rx_head_reg[p] <= '0;
                    rx_tail_reg[p] <= '0;
                end
                stop_reg <= '0;
            end
            else if (present)
            begin
                tx_head_reg[port_idx] <= th_next;
                tx_tail_reg[port_idx] <= tt_next;
                rx_head_reg[port_idx] <= rh_next;
                rx_tail_reg[port_idx] <= rt_next;
                stop_reg[port_idx]    <= stop_next;
            end
            avail_reg    <= avail_next;
            io_avail_reg <= io_avail_next;
        end
    end

    // ---------------- ring memories ----------------
    always_ff @(posedge clk)
    begin
        if (step && tx_we)
        begin
            tx_mem[base_addr + ADDR_W'(th)] <= in_data_reg;
        end
        if (step && res.tx_sel)
        begin
            tx_rd_reg <= tx_mem[base_addr + ADDR_W'(tt)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && rx_we)
        begin
            rx_mem[base_addr + ADDR_W'(rh)] <= in_data_reg;
        end
        if (step && res.rx_sel)
        begin
            rx_rd_reg <= rx_mem[base_addr + ADDR_W'(rt)];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= res;
        end
    end

    logic [mpcm_pkg::BYTE_W-1:0] data_out;

    always_comb
    begin
        priority if (out_reg.tx_sel)
        begin
            data_out = tx_rd_reg;
        end
        else if (out_reg.rx_sel)
        begin
            data_out = rx_rd_reg;
        end
        else
        begin
            data_out = out_reg.data_out;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.data_valid;
    assign m_axis_tdata  = {6'b0, out_reg.push_dropped, out_reg.status_update,
                            out_reg.io_avail, out_reg.avail_mask, out_reg.rx_empty,
                            out_reg.tx_half_full, out_reg.tx_full, out_reg.tx_empty,
                            data_out};

    // ---------------- assertions ----------------
    `MPCM_ASSERT_IMPL(a_io_needs_avail, io_avail_reg, avail_reg != '0,
        "io_avail set with no port avail bit")
    `MPCM_ASSERT_IMPL(a_full_not_empty, out_valid_reg && out_reg.tx_full, !out_reg.tx_empty,
        "transmit ring reported both full and empty")
    `MPCM_ASSERT_IMPL(a_drop_when_full, out_valid_reg && out_reg.push_dropped, out_reg.tx_full,
        "push dropped while ring not full")
    `MPCM_ASSERT_NEXT(a_init_clears, step && (in_mode_reg == mpcm_pkg::MODE_INIT),
        (avail_reg == '0) && !io_avail_reg && (stop_reg == '0),
        "init did not clear avail and stop state")

endmodule

@@ sim/tb_multi_port_char_mailbox_rings.sv @@
// Self-checking testbench for the multi-port character mailbox rings.
// Depends on mpcm_pkg and the multi_port_char_mailbox_rings top level; a built-in
// mailbox predictor checks every result transfer against the commands sent.
module tb_multi_port_char_mailbox_rings;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH   = 256;
    localparam int PORT_COUNT   = 3;
    localparam int RANDOM_ITEMS = 1650;

    typedef struct packed {
        logic [7:0] data_out;
        logic       data_valid;
        logic       tx_empty;
        logic       tx_full;
        logic       tx_half_full;
        logic       rx_empty;
        logic [2:0] avail_mask;
        logic       io_avail;
        logic       status_update;
        logic       push_dropped;
    } mbx_reply_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [mpcm_pkg::BYTE_W-1:0]     cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [mpcm_pkg::BYTE_W-1:0]     s_axis_tdata;   // [7:0] data_in
    logic [mpcm_pkg::IN_USER_W-1:0]  s_axis_tuser;   // [2:0] mode, [4:3] port
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // [7:0] data_out, [8] tx_empty, [9] tx_full, [10] tx_half_full, [11] rx_empty,
    // [14:12] avail_mask, [15] io_avail, [16] status_update, [17] push_dropped
    logic [mpcm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;   // data_valid

    // Mailbox predictor state
    logic [7:0] tx_mem [PORT_COUNT][RING_DEPTH];
    logic [7:0] rx_mem [PORT_COUNT][RING_DEPTH];
    int         tx_wr [PORT_COUNT];
    int         tx_rd [PORT_COUNT];
    int         rx_wr [PORT_COUNT];
    int         rx_rd [PORT_COUNT];
    bit         stop_mark [PORT_COUNT];
    logic [2:0] avail_bits;
    logic       io_flag;
    logic [7:0] term_byte;

    mbx_reply_t pending_replies[$];
    int         fail_count;
    int         cmds_sent;
    bit         send_quiet;
    bit         recv_quiet;

    multi_port_char_mailbox_rings uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12_000_000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic int ring_next(int idx);
        return (idx + 1) % RING_DEPTH;
    endfunction

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // Port 3 is absent; address it now and then.
    function automatic logic [1:0] pick_port();
        return ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    endfunction

    function automatic mbx_reply_t predict_mailbox_reply(mpcm_pkg::mode_t m, logic [1:0] p,
                                                         logic [7:0] d);
        mbx_reply_t r;
        int         pi;
        int         fill;
        logic [2:0] pbit;
        r = '0;
        r.tx_empty = 1'b1;
        r.rx_empty = 1'b1;
        pi = int'(p);
        if (m == mpcm_pkg::MODE_INIT)
        begin
            for (int k = 0; k < PORT_COUNT; k++)
            begin
                tx_wr[k] = 0;
                tx_rd[k] = 0;
                rx_wr[k] = 0;
                rx_rd[k] = 0;
                tx_mem[k][0] = 8'h00;
                rx_mem[k][0] = 8'h00;
                stop_mark[k] = 1'b0;
            end
            avail_bits = '0;
            io_flag = 1'b0;
            r.status_update = 1'b1;
        end
        else if (pi < PORT_COUNT)
        begin
            pbit = 3'b001 << pi;
            case (m)
                mpcm_pkg::MODE_BUS_READ:
                begin
                    r.data_valid = 1'b1;
                    if (tx_wr[pi] == tx_rd[pi])
                    begin
                        r.data_out = term_byte;
                        // second empty read in a row ends the output session
                        if (stop_mark[pi])
                        begin
                            avail_bits &= ~pbit;
                            io_flag = 1'b0;
                            r.status_update = 1'b1;
                        end
                        else
                            stop_mark[pi] = 1'b1;
                    end
                    else
                    begin
                        r.data_out = tx_mem[pi][tx_rd[pi]];
                        tx_rd[pi] = ring_next(tx_rd[pi]);
                        stop_mark[pi] = 1'b0;
                    end
                end
                mpcm_pkg::MODE_BUS_WRITE:
                begin
                    rx_mem[pi][rx_wr[pi]] = d;
                    rx_wr[pi] = ring_next(rx_wr[pi]);
                    // overwrite the oldest byte when full
                    if (rx_wr[pi] == rx_rd[pi])
                        rx_rd[pi] = ring_next(rx_rd[pi]);
                end
                mpcm_pkg::MODE_TX_PUSH:
                begin
                    if (ring_next(tx_wr[pi]) == tx_rd[pi])
                        r.push_dropped = 1'b1;
                    else
                    begin
                        tx_mem[pi][tx_wr[pi]] = d;
                        tx_wr[pi] = ring_next(tx_wr[pi]);
                    end
                end
                mpcm_pkg::MODE_RX_POP:
                begin
                    if (rx_wr[pi] != rx_rd[pi])
                    begin
                        r.data_out = rx_mem[pi][rx_rd[pi]];
                        r.data_valid = 1'b1;
                        rx_rd[pi] = ring_next(rx_rd[pi]);
                    end
                end
                mpcm_pkg::MODE_TX_FLUSH:
                begin
                    tx_wr[pi] = 0;
                    tx_rd[pi] = 0;
                end
                mpcm_pkg::MODE_RX_FLUSH:
                begin
                    rx_wr[pi] = 0;
                    rx_rd[pi] = 0;
                end
                default:
                begin
                    if (tx_wr[pi] != tx_rd[pi])
                    begin
                        avail_bits |= pbit;
                        io_flag = 1'b1;
                        r.status_update = 1'b1;
                    end
                end
            endcase
        end
        if (pi < PORT_COUNT)
        begin
            fill = (tx_wr[pi] - tx_rd[pi] + RING_DEPTH) % RING_DEPTH;
            r.tx_empty = (tx_wr[pi] == tx_rd[pi]);
            r.tx_full = (ring_next(tx_wr[pi]) == tx_rd[pi]);
            r.tx_half_full = (fill > RING_DEPTH / 2);
            r.rx_empty = (rx_wr[pi] == rx_rd[pi]);
        end
        r.avail_mask = avail_bits;
        r.io_avail = io_flag;
        return r;
    endfunction

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(mpcm_pkg::mode_t m, logic [1:0] p, logic [7:0] d);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= {p, m};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_replies.push_back(predict_mailbox_reply(m, p, d));
        cmds_sent++;
        @(negedge clk);
    endtask

    // Hold off new commands until every result is back and the pipe is empty.
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_terminator(logic [7:0] value);
        drain_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        term_byte = value;
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Result receiver: random stalls, with quiet stretches now and then.
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                recv_quiet = ~recv_quiet;
            gap = draw_gap(recv_quiet);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        mbx_reply_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                fail_count++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                check_field("data_out", exp_r.data_out, m_axis_tdata[7:0]);
                check_field("data_valid", exp_r.data_valid, m_axis_tuser);
                check_field("tx_empty", exp_r.tx_empty, m_axis_tdata[8]);
                check_field("tx_full", exp_r.tx_full, m_axis_tdata[9]);
                check_field("tx_half_full", exp_r.tx_half_full, m_axis_tdata[10]);
                check_field("rx_empty", exp_r.rx_empty, m_axis_tdata[11]);
                check_field("avail_mask", exp_r.avail_mask, m_axis_tdata[14:12]);
                check_field("io_avail", exp_r.io_avail, m_axis_tdata[15]);
                check_field("status_update", exp_r.status_update, m_axis_tdata[16]);
                check_field("push_dropped", exp_r.push_dropped, m_axis_tdata[17]);
            end
        end
    end

    task automatic test_directed_corners();
        send_quiet = 1'b0;
        // empty reads with the reset terminator: arm stop mark, then end session
        send_cmd(mpcm_pkg::MODE_BUS_READ, 2'd0, 8'h00);
        send_cmd(mpcm_pkg::MODE_BUS_READ, 2'd0, 8'hFF);
        set_terminator(8'hFF);
        send_cmd(mpcm_pkg::MODE_RX_POP, 2'd1, 8'h00);
        send_cmd(mpcm_pkg::MODE_START_OUT, 2'd2, 8'h00);
        send_cmd(mpcm_pkg::MODE_TX_PUSH, 2'd0, 8'h00);
        send_cmd(mpcm_pkg::MODE_TX_PUSH, 2'd0, 8'hFF);
        send_cmd(mpcm_pkg::MODE_START_OUT, 2'd0, 8'h00);
        send_cmd(mpcm_pkg::MODE_BUS_READ, 2'd0, 8'h00);
        send_cmd(mpcm_pkg::MODE_BUS_READ, 2'd0, 8'h00);
        send_cmd(mpcm_pkg::MODE_BUS_READ, 2'd0, 8'h00);
        send_cmd(mpcm_pkg::MODE_BUS_READ, 2'd0, 8'h00);
        send_cmd(mpcm_pkg::MODE_BUS_WRITE, 2'd1, 8'hA5);
        send_cmd(mpcm_pkg::MODE_BUS_WRITE, 2'd1, 8'h5A);
        send_cmd(mpcm_pkg::MODE_RX_POP, 2'd1, 8'h00);
        send_cmd(mpcm_pkg::MODE_TX_PUSH, 2'd2, 8'h3C);
        send_cmd(mpcm_pkg::MODE_START_OUT, 2'd2, 8'h00);
        send_cmd(mpcm_pkg::MODE_TX_FLUSH, 2'd2, 8'h00);
        send_cmd(mpcm_pkg::MODE_RX_FLUSH, 2'd1, 8'h00);
        // absent port: no effect but for init, which still clears every port; fixed flags
        send_cmd(mpcm_pkg::MODE_BUS_READ, 2'd3, 8'h00);
        send_cmd(mpcm_pkg::MODE_TX_PUSH, 2'd3, 8'hC3);
        send_cmd(mpcm_pkg::MODE_BUS_WRITE, 2'd3, 8'h81);
        send_cmd(mpcm_pkg::MODE_START_OUT, 2'd3, 8'h00);
        send_cmd(mpcm_pkg::MODE_INIT, 2'd3, 8'h00);
        send_cmd(mpcm_pkg::MODE_INIT, 2'd0, 8'h00);
    endtask

    // Fill both ring kinds past full, then drain them dry.
    task automatic test_ring_limits();
        logic [1:0] p;
        set_terminator(8'h00);
        send_quiet = 1'b1;
        p = 2'($urandom_range(0, 2));
        for (int i = 0; i < RING_DEPTH + 2; i++)
            send_cmd(mpcm_pkg::MODE_TX_PUSH, p, 8'($urandom_range(0, 255)));
        send_quiet = 1'b0;
        send_cmd(mpcm_pkg::MODE_START_OUT, p, 8'h00);
        for (int i = 0; i < RING_DEPTH + 2; i++)
        begin
            if (i % 64 == 0)
                send_quiet = ~send_quiet;
            send_cmd(mpcm_pkg::MODE_BUS_READ, p, 8'h00);
        end
        p = 2'($urandom_range(0, 2));
        for (int i = 0; i < RING_DEPTH + 2; i++)
            send_cmd(mpcm_pkg::MODE_BUS_WRITE, p, 8'($urandom_range(0, 255)));
        for (int i = 0; i < RING_DEPTH + 1; i++)
            send_cmd(mpcm_pkg::MODE_RX_POP, p, 8'h00);
    endtask

    task automatic test_random_traffic(int first_cmd);
        int         kind;
        int         n;
        logic [1:0] p;
        while (cmds_sent - first_cmd < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
                set_terminator(8'($urandom_range(0, 255)));
            send_quiet = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            p = pick_port();
            if (kind < 35)
            begin
                n = $urandom_range(1, 40);
                for (int i = 0; i < n; i++)
                    send_cmd(mpcm_pkg::MODE_TX_PUSH, p, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) != 0)
                    send_cmd(mpcm_pkg::MODE_START_OUT, p, 8'($urandom_range(0, 255)));
                n = n + $urandom_range(0, 3) - $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    send_cmd(mpcm_pkg::MODE_BUS_READ, p, 8'($urandom_range(0, 255)));
            end
            else if (kind < 60)
            begin
                n = $urandom_range(1, 40);
                for (int i = 0; i < n; i++)
                    send_cmd(mpcm_pkg::MODE_BUS_WRITE, p, 8'($urandom_range(0, 255)));
                n = $urandom_range(0, n + 2);
                for (int i = 0; i < n; i++)
                    send_cmd(mpcm_pkg::MODE_RX_POP, p, 8'($urandom_range(0, 255)));
            end
            else if (kind < 92)
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                begin
                    // mostly traffic modes; flushes and init are rare here
                    send_cmd(($urandom_range(0, 9) == 0)
                                 ? mpcm_pkg::mode_t'($urandom_range(4, 7))
                                 : mpcm_pkg::mode_t'($urandom_range(0, 3)),
                             pick_port(), 8'($urandom_range(0, 255)));
                end
            end
            else if (kind < 97)
                send_cmd($urandom_range(0, 1) ? mpcm_pkg::MODE_TX_FLUSH
                                              : mpcm_pkg::MODE_RX_FLUSH,
                         p, 8'($urandom_range(0, 255)));
            else
                send_cmd(mpcm_pkg::MODE_INIT, p, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int first_random;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        fail_count    = 0;
        cmds_sent     = 0;
        send_quiet    = 1'b0;
        recv_quiet    = 1'b0;
        for (int k = 0; k < PORT_COUNT; k++)
        begin
            tx_wr[k] = 0;
            tx_rd[k] = 0;
            rx_wr[k] = 0;
            rx_rd[k] = 0;
            stop_mark[k] = 1'b0;
        end
        avail_bits = '0;
        io_flag    = 1'b0;
        term_byte  = 8'h00;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_corners();
        first_random = cmds_sent;
        test_ring_limits();
        test_random_traffic(first_random);

        drain_replies();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
